// File: rtl/cdd_pkg.sv
// cdd_pkg: types, constants and calendar tables shared by the day difference block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

  localparam int unsigned YearW = 15;
  localparam int unsigned DoyW  = 18;
  localparam int unsigned AccW  = 25;
  localparam int unsigned OutW  = 23;

  // one normalized date as the back end needs it
  typedef struct packed {
    logic [YearW-1:0]       year;
    logic signed [DoyW-1:0] doy;
    logic                   leap;
    logic [6:0]             r100;
    logic [1:0]             q4;
  } date_t;

  typedef struct packed {
    date_t a;
    date_t b;
  } entry_t;

  // queue status seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_out_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] acc;
    case (m)
      4'd1:    acc = 9'd0;
      4'd2:    acc = 9'd31;
      4'd3:    acc = 9'd59;
      4'd4:    acc = 9'd90;
      4'd5:    acc = 9'd120;
      4'd6:    acc = 9'd151;
      4'd7:    acc = 9'd181;
      4'd8:    acc = 9'd212;
      4'd9:    acc = 9'd243;
      4'd10:   acc = 9'd273;
      4'd11:   acc = 9'd304;
      default: acc = 9'd334;
    endcase
    if (leap && (m > 4'd2)) begin
      acc = acc + 9'd1;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cdd_in_if.sv
// cdd_in_if: input channel carrying two raw dates and the day offset
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cdd_in_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  first_day;
  logic signed [7:0]  first_month;
  logic signed [14:0] first_year;
  logic signed [16:0] first_offset;
  logic signed [7:0]  second_day;
  logic signed [7:0]  second_month;
  logic signed [14:0] second_year;

  modport source (output valid, first_day, first_month, first_year, first_offset,
                  second_day, second_month, second_year, input ready);
  modport sink (input valid, first_day, first_month, first_year, first_offset,
                second_day, second_month, second_year, output ready);
endinterface

`default_nettype wire

// File: rtl/cdd_out_if.sv
// cdd_out_if: result channel carrying the day count
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cdd_out_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] day_count;

  modport source (output valid, day_count, input ready);
  modport sink (input valid, day_count, output ready);
endinterface

`default_nettype wire

// File: rtl/cdd_front.sv
// cdd_front: takes raw dates, normalizes them and pushes them into the queue
// depends on cdd_pkg and cdd_in_if
`timescale 1ns / 1ps
`default_nettype none

module cdd_front (
  input  wire logic     clk,
  input  wire logic     rst,
  cdd_in_if.sink        dates,
  output logic          push,
  output cdd_pkg::entry_t entry,
  input  wire logic     full
);

  typedef struct packed {
    logic [7:0]                  dm;
    logic [7:0]                  mm;
    logic [3:0]                  mq;
    logic [cdd_pkg::YearW-1:0]   ym;
    logic [7:0]                  yq;
  } raw_t;

  function automatic raw_t prep(input logic [7:0] d, input logic [7:0] m,
                                input logic [cdd_pkg::YearW-1:0] y);
    logic [13:0] mp;
    logic [27:0] yp;
    raw_t r;
    r.dm = d[7] ? (~d + 8'd1) : d;
    r.mm = m[7] ? (~m + 8'd1) : m;
    r.ym = y[cdd_pkg::YearW-1] ? (~y + 15'd1) : y;
    // divide by 12 and by 100 through reciprocals
    mp = 14'(r.mm) * 14'd43;
    yp = 28'(r.ym) * 28'd5243;
    r.mq = mp[12:9];
    r.yq = yp[26:19];
    return r;
  endfunction

  function automatic cdd_pkg::date_t finish(input raw_t r);
    logic [7:0]  mrem;
    logic [3:0]  mn;
    logic [14:0] yrem;
    logic [4:0]  len;
    logic [7:0]  dn;
    logic [8:0]  doy;
    cdd_pkg::date_t o;
    mrem = r.mm - {1'b0, r.mq, 3'b000} - {2'b00, r.mq, 2'b00};
    mn = (mrem[3:0] == 4'd0) ? 4'd12 : mrem[3:0];
    yrem = r.ym - (15'(r.yq) * 15'd100);
    o.year = r.ym;
    o.r100 = yrem[6:0];
    o.q4 = r.yq[1:0];
    o.leap = (o.r100 == 7'd0) ? (o.q4 == 2'd0) : (r.ym[1:0] == 2'b00);
    len = cdd_pkg::month_days(mn, o.leap);
    dn = (r.dm > 8'(len)) ? 8'd1 : r.dm;
    doy = cdd_pkg::days_before(mn, o.leap) + 9'(dn);
    o.doy = signed'(18'(doy));
    return o;
  endfunction

  logic        v1;
  raw_t        ra;
  raw_t        rb;
  logic signed [16:0] off;
  cdd_pkg::date_t da;

  assign push = v1 && !full;
  assign dates.ready = !v1 || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (dates.ready) begin
      v1 <= dates.valid;
    end
    if (dates.ready && dates.valid) begin
      ra  <= prep(dates.first_day, dates.first_month, dates.first_year);
      rb  <= prep(dates.second_day, dates.second_month, dates.second_year);
      off <= dates.first_offset;
    end
  end

  always_comb begin
    da = finish(ra);
    da.doy = da.doy + {off[16], off};
    entry.a = da;
    entry.b = finish(rb);
  end

endmodule

`default_nettype wire

// File: rtl/cdd_queue.sv
// cdd_queue: two-entry queue between the front and back ends
// depends on cdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cdd_pkg::entry_t  entry,
  output logic                  full,
  input  wire logic             pop,
  output cdd_pkg::q_out_t       head
);

  cdd_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cdd_back.sv
// cdd_back: orders two dates and counts the days between them, one year a cycle
// depends on cdd_pkg and cdd_out_if
`timescale 1ns / 1ps
`default_nettype none

module cdd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cdd_pkg::q_out_t  head,
  output logic                  pop,
  cdd_out_if.source             result
);

  typedef enum logic [1:0] {IDLE, ORDER, LOOP, DONE} state_t;

  function automatic logic signed [cdd_pkg::AccW-1:0] sx(
      input logic signed [cdd_pkg::DoyW-1:0] v);
    return {{(cdd_pkg::AccW-cdd_pkg::DoyW){v[cdd_pkg::DoyW-1]}}, v};
  endfunction

  state_t          state;
  cdd_pkg::entry_t cur_entry;
  cdd_pkg::date_t  e;
  cdd_pkg::date_t  l;
  logic            a_first;
  logic [cdd_pkg::YearW-1:0] ly;
  logic [cdd_pkg::YearW-1:0] cur;
  logic [6:0]      c100;
  logic [1:0]      c400;
  logic            cur_leap;
  logic signed [cdd_pkg::AccW-1:0] acc;
  logic            out_valid;
  logic signed [cdd_pkg::OutW-1:0] out_count;

  assign pop = (state == IDLE) && head.valid;
  assign result.valid = out_valid;
  assign result.day_count = out_count;

  always_comb begin
    a_first = (cur_entry.a.year < cur_entry.b.year) ||
              ((cur_entry.a.year == cur_entry.b.year) && (cur_entry.a.doy < cur_entry.b.doy));
    e = a_first ? cur_entry.a : cur_entry.b;
    l = a_first ? cur_entry.b : cur_entry.a;
    cur_leap = (c100 == 7'd0) ? (c400 == 2'd0) : (cur[1:0] == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (head.valid) begin
            cur_entry <= head.data;
            state     <= ORDER;
          end
        end
        ORDER: begin
          ly <= l.year;
          if (e.year == l.year) begin
            out_count <= cdd_pkg::OutW'(l.doy - e.doy);
            out_valid <= 1'b1;
            state     <= DONE;
          end else begin
            acc  <= cdd_pkg::AccW'(365) - sx(e.doy) + sx(l.doy) +
                    cdd_pkg::AccW'(e.leap);
            cur  <= e.year + 15'd1;
            c100 <= (e.r100 == 7'd99) ? 7'd0 : e.r100 + 7'd1;
            c400 <= (e.r100 == 7'd99) ? e.q4 + 2'd1 : e.q4;
            state <= LOOP;
          end
        end
        LOOP: begin
          if (cur == ly) begin
            out_count <= acc[cdd_pkg::OutW-1:0];
            out_valid <= 1'b1;
            state     <= DONE;
          end else begin
            // whole intermediate year
            acc  <= acc + cdd_pkg::AccW'(365) + cdd_pkg::AccW'(cur_leap);
            cur  <= cur + 15'd1;
            c100 <= (c100 == 7'd99) ? 7'd0 : c100 + 7'd1;
            c400 <= (c100 == 7'd99) ? c400 + 2'd1 : c400;
          end
        end
        DONE: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/calendar_day_difference.sv
// calendar_day_difference: days between two Gregorian dates
// dates within one year skip the year loop; otherwise the back end adds each intermediate year in turn
// the front end keeps taking items into a two-entry queue while the back end counts, until the queue is full
// reset: synchronous, active high; clears queue, pipeline valid and back-end state
// depends on cdd_pkg, cdd_in_if, cdd_out_if, cdd_front, cdd_queue, cdd_back
`timescale 1ns / 1ps
`default_nettype none

module calendar_day_difference (
  input  wire logic clk,
  input  wire logic rst,
  cdd_in_if.sink    dates,
  cdd_out_if.source result
);

  logic            push;
  logic            q_full;
  logic            pop;
  cdd_pkg::entry_t entry;
  cdd_pkg::q_out_t head;

  cdd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .dates (dates),
    .push  (push),
    .entry (entry),
    .full  (q_full)
  );

  cdd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  cdd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

`ifndef ASSERT_OFF
  // no push into a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("push into full queue");
  // a queued item stays until popped
  assert property (@(posedge clk) disable iff (rst) (head.valid && !pop) |=> head.valid)
    else $error("queued item lost");
  // pop only with a queued item
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for calendar_day_difference: directed date pairs, then random ones,
// each day count checked against a known count or a day-of-year predictor kept in this file
// depends on cdd_in_if, cdd_out_if and calendar_day_difference
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 400;
  localparam int RandomPairs = 76;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic signed [7:0]  first_day;
    logic signed [7:0]  first_month;
    logic signed [14:0] first_year;
    logic signed [16:0] first_offset;
    logic signed [7:0]  second_day;
    logic signed [7:0]  second_month;
    logic signed [14:0] second_year;
  } date_pair_t;

  typedef struct packed {
    date_pair_t  pair;
    logic        known;
    logic [22:0] count;
  } dir_row_t;

  // known counts only where they follow directly from the calendar
  dir_row_t directed_rows [24] = '{
    '{'{8'sd0, 8'sd0, 15'sd0, 17'sd0, 8'sd0, 8'sd0, 15'sd0}, 1'b1, 23'd0},
    '{'{8'sd1, 8'sd1, 15'sd2000, 17'sd0, 8'sd1, 8'sd1, 15'sd2001}, 1'b1, 23'd366},
    '{'{8'sd1, 8'sd1, 15'sd2001, 17'sd0, 8'sd1, 8'sd1, 15'sd2000}, 1'b1, 23'd366},
    '{'{8'sd1, 8'sd1, 15'sd2001, 17'sd0, 8'sd1, 8'sd1, 15'sd2002}, 1'b1, 23'd365},
    '{'{8'sd1, 8'sd1, 15'sd1900, 17'sd0, 8'sd1, 8'sd1, 15'sd1901}, 1'b1, 23'd365},
    '{'{8'sd1, 8'sd1, 15'sd2000, 17'sd1, 8'sd1, 8'sd1, 15'sd2000}, 1'b1, 23'd1},
    '{'{8'sd1, 8'sd1, 15'sd2000, -17'sd1, 8'sd1, 8'sd1, 15'sd2000}, 1'b1, 23'd1},
    '{'{8'sd29, 8'sd2, 15'sd2000, 17'sd0, 8'sd1, 8'sd3, 15'sd2000}, 1'b1, 23'd1},
    '{'{8'sd29, 8'sd2, 15'sd2001, 17'sd0, 8'sd1, 8'sd2, 15'sd2001}, 1'b1, 23'd0},
    '{'{-8'sd5, -8'sd3, -15'sd2020, 17'sd0, 8'sd5, 8'sd3, 15'sd2020}, 1'b1, 23'd0},
    '{'{8'sd1, 8'sd13, 15'sd2000, 17'sd0, 8'sd1, 8'sd1, 15'sd2000}, 1'b1, 23'd0},
    '{'{8'sd1, -8'sd24, 15'sd2000, 17'sd0, 8'sd1, 8'sd12, 15'sd2000}, 1'b1, 23'd0},
    '{'{8'sd0, 8'sd3, 15'sd2001, 17'sd0, 8'sd28, 8'sd2, 15'sd2001}, 1'b1, 23'd0},
    '{'{8'h80, 8'h80, 15'h4000, 17'sd0, 8'sd1, 8'sd8, 15'h4000}, 1'b1, 23'd0},
    '{'{8'sd99, 8'sd99, 15'sd9999, 17'sd0, -8'sd99, -8'sd99, -15'sd9999}, 1'b1, 23'd0},
    '{'{8'sd31, 8'sd12, 15'sd1999, 17'sd0, 8'sd1, 8'sd1, 15'sd2000}, 1'b1, 23'd1},
    '{'{8'sd31, 8'sd12, 15'sd2000, 17'sd0, 8'sd1, 8'sd1, 15'sd2001}, 1'b1, 23'd1},
    '{'{8'sd1, 8'sd1, 15'sd0, 17'sd65535, 8'sd1, 8'sd1, 15'sd0}, 1'b1, 23'd65535},
    '{'{8'sd1, 8'sd1, 15'sd5, 17'h10000, 8'sd1, 8'sd1, 15'sd5}, 1'b1, 23'd65536},
    '{'{8'sd1, 8'sd1, 15'sd0, 17'sd0, 8'sd1, 8'sd1, 15'h4000}, 1'b0, 23'd0},
    '{'{8'sd31, 8'sd12, 15'sd16383, 17'h10000, 8'sd1, 8'sd1, -15'sd1}, 1'b0, 23'd0},
    '{'{8'sd1, 8'sd1, 15'sd1600, 17'sd0, 8'sd1, 8'sd1, 15'sd2400}, 1'b0, 23'd0},
    '{'{8'sd1, 8'sd1, 15'sd2000, 17'sd400, 8'sd1, 8'sd1, 15'sd2001}, 1'b0, 23'd0},
    '{'{8'h7f, 8'h7f, 15'h3fff, 17'h0ffff, 8'hff, 8'hff, 15'h7fff}, 1'b0, 23'd0}
  };

  logic clk;
  logic rst;
  cdd_in_if  dates_ch ();
  cdd_out_if result_ch ();

  calendar_day_difference dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates_ch),
    .result (result_ch)
  );

  logic [22:0] pending_counts [$];
  int          faults;
  int          counts_checked;
  int          pairs_sent;
  int          cycle_count;
  bit          no_idle;

  function automatic bit leap_year(input longint y);
    if (y % 100 == 0) return (y % 400 == 0);
    return (y % 4 == 0);
  endfunction

  // leap years in 0..n
  function automatic longint leaps_through(input longint n);
    return n / 4 - n / 100 + n / 400 + 1;
  endfunction

  function automatic void year_and_day(input logic signed [7:0] day_raw,
                                       input logic signed [7:0] month_raw,
                                       input logic signed [14:0] year_raw,
                                       output longint year, output longint doy);
    longint d;
    longint m;
    longint len;
    bit     lp;
    d = day_raw;
    m = month_raw;
    year = year_raw;
    if (d < 0) d = -d;
    if (m < 0) m = -m;
    if (year < 0) year = -year;
    lp = leap_year(year);
    m = m % 12;
    if (m == 0) m = 12;
    len = MonthDays[m - 1];
    if (m == 2 && lp) len = 29;
    if (d > len) d = 1;
    doy = d;
    for (int i = 0; i < m - 1; i++) begin
      doy += MonthDays[i];
      if (i == 1 && lp) doy++;
    end
  endfunction

  function automatic longint span_days(input longint ey, input longint ed,
                                       input longint ly, input longint ld);
    longint n;
    if (ey == ly) return ld - ed;
    n = 365 * (ly - ey - 1);
    if (ly - 1 >= ey + 1) n += leaps_through(ly - 1) - leaps_through(ey);
    n += 365 - ed + ld;
    if (leap_year(ey)) n++;
    return n;
  endfunction

  function automatic logic [22:0] predict_day_count(input date_pair_t p);
    longint ay, ad, by, bd, n;
    year_and_day(p.first_day, p.first_month, p.first_year, ay, ad);
    ad += longint'(p.first_offset);
    year_and_day(p.second_day, p.second_month, p.second_year, by, bd);
    if (ay < by || (ay == by && ad < bd)) n = span_days(ay, ad, by, bd);
    else n = span_days(by, bd, ay, ad);
    return n[22:0];
  endfunction

  function automatic logic signed [14:0] raw_year(input int mag);
    if (mag >= 16384) return 15'h4000;
    if ($urandom_range(1) == 1) return 15'(-mag);
    return 15'(mag);
  endfunction

  function automatic logic signed [7:0] raw_field(input int span);
    if ($urandom_range(3) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic date_pair_t random_pair(input bit long_span);
    date_pair_t p;
    int         y1, y2;
    y1 = $urandom_range(0, 16384);
    if (long_span) y2 = $urandom_range(0, 16384);
    else if ($urandom_range(4) == 0) y2 = y1;
    else y2 = y1 + int'($urandom_range(0, 80)) - 40;
    if (y2 < 0) y2 = 0;
    if (y2 > 16384) y2 = 16384;
    p.first_day    = raw_field(31);
    p.first_month  = raw_field(14);
    p.first_year   = raw_year(y1);
    p.second_day   = raw_field(31);
    p.second_month = raw_field(14);
    p.second_year  = raw_year(y2);
    if ($urandom_range(6) == 0) p.first_offset = 17'($urandom);
    else p.first_offset = 17'(int'($urandom_range(0, 800)) - 400);
    return p;
  endfunction

  task automatic send_pair(input date_pair_t p, input logic [22:0] count);
    while (!no_idle && $urandom_range(99) < 27) begin
      dates_ch.valid = 1'b0;
      @(negedge clk);
    end
    dates_ch.first_day    = p.first_day;
    dates_ch.first_month  = p.first_month;
    dates_ch.first_year   = p.first_year;
    dates_ch.first_offset = p.first_offset;
    dates_ch.second_day   = p.second_day;
    dates_ch.second_month = p.second_month;
    dates_ch.second_year  = p.second_year;
    dates_ch.valid        = 1'b1;
    @(posedge clk);
    while (dates_ch.ready !== 1'b1) @(posedge clk);
    pending_counts.push_back(count);
    pairs_sent++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycle_count,
               pending_counts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result checking on every transfer
  always @(posedge clk) begin
    logic [22:0] want;
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_counts.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected day count %0d", $signed(result_ch.day_count));
        end
      end else begin
        want = pending_counts.pop_front();
        counts_checked++;
        if (result_ch.day_count !== want) begin
          faults++;
          if (faults <= 10) begin
            $display("day count mismatch: expected %0d got %0d", $signed(want),
                     $signed(result_ch.day_count));
          end
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int  held;
    bit  hold_done;
    hold_done = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && counts_checked >= 30) begin
        result_ch.ready = 1'b0;
        for (held = 0; held < HoldCycles; held++) @(negedge clk);
        hold_done = 1'b1;
      end
      result_ch.ready = no_idle || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    date_pair_t  p;
    logic [22:0] count;
    int          long_spans;
    faults = 0;
    counts_checked = 0;
    pairs_sent = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    long_spans = 0;
    rst = 1'b1;
    dates_ch.valid = 1'b0;
    dates_ch.first_day = '0;
    dates_ch.first_month = '0;
    dates_ch.first_year = '0;
    dates_ch.first_offset = '0;
    dates_ch.second_day = '0;
    dates_ch.second_month = '0;
    dates_ch.second_year = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      p = directed_rows[i].pair;
      count = directed_rows[i].known ? directed_rows[i].count : predict_day_count(p);
      send_pair(p, count);
    end

    for (int i = 0; i < RandomPairs; i++) begin
      if (i == 50) begin
        dates_ch.valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge clk);
      end
      no_idle = (i >= 55 && i < 75);
      if (i % 33 == 16) long_spans++;
      p = random_pair(i % 33 == 16);
      send_pair(p, predict_day_count(p));
    end
    no_idle = 1'b0;
    dates_ch.valid = 1'b0;

    while (pending_counts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d date pairs (%0d directed, %0d random with %0d full-range spans)",
             pairs_sent, $size(directed_rows), RandomPairs, long_spans);
    $display("%0d day counts compared, %0d faults, %0d cycles", counts_checked, faults,
             cycle_count);
    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
